### rtl/bcl_pkg.sv
`timescale 1ns / 1ps
// Package: sizes, types and constants of the component labeler.
package bcl_pkg;
	localparam int MAX_WIDTH = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int MAX_COMPONENTS = 1024;
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int PW = XW + YW;
	localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;
	localparam int CW = $clog2(MAX_COMPONENTS);
	localparam int DW = 9;
	localparam int LW = 11;
	localparam logic [0:0] REG_WIDTH = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef struct packed {
		logic [XW-1:0] left;
		logic [YW-1:0] top;
		logic [XW-1:0] right;
		logic [YW-1:0] bottom;
	} box_t;

	typedef struct packed {
		logic action;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	typedef struct packed {
		logic comp_valid;
		logic [LW-1:0] comp_label;
		logic [7:0] box_left;
		logic [7:0] box_top;
		logic [7:0] box_right;
		logic [7:0] box_bottom;
		logic last_component;
		logic table_overflow;
	} comp_t;

	typedef struct packed {
		logic index;
		logic [DW-1:0] data;
	} cfg_t;
endpackage

### rtl/bcl_if.sv
`timescale 1ns / 1ps
// Interfaces: valid/ready channels for pixels, components and configuration.
interface bcl_pix_if import bcl_pkg::*; ();
	logic valid;
	logic ready;
	pix_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface bcl_comp_if import bcl_pkg::*; ();
	logic valid;
	logic ready;
	comp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface bcl_cfg_if import bcl_pkg::*; ();
	logic valid;
	logic ready;
	cfg_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### rtl/bcl_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
module bcl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

### rtl/binary_component_labeler_core.sv
`timescale 1ns / 1ps
// Top level: 8-connected component labeler with bounding boxes.
//
// Channels: pix (action, red, green, blue), comp (one result per read item),
// cfg (index 0 width, 1 height; write only while idle, restarts loading).
// A load item is thresholded when accepted, then written to the dark bitmap in S_LOAD.
// The last pixel of the frame starts labeling. Labeling first clears the
// visited map, one entry a cycle, then scans pixels in raster order (S_SCAN,
// S_SCANRD), with a flood fill for each new component.
// The fill pops one queue entry (S_POP, S_POPRD), then steps through the 3x3
// window (nine probes, center skipped), each probe a dark read and a visited
// read on the single-ported memories (S_NB, S_NBRD). A box is stored in S_STORE.
// No item is accepted during labeling.
// A read item fetches the next stored box from the box table; S_READ reads it
// and S_READRD registers the result.
// Results wait in an output register; while the receiver stalls, no new
// item is accepted. Reset clears all control state and the counters; the
// dark bitmap, queue and box table hold garbage until written.
module binary_component_labeler_core import bcl_pkg::*; (
	input logic clk,
	input logic arst_n,
	bcl_pix_if.sink pix,
	bcl_comp_if.source comp,
	bcl_cfg_if.sink cfg
);
	typedef enum logic [11:0] {
		S_IDLE   = 12'b000000000001,
		S_LOAD   = 12'b000000000010,
		S_CLEAR  = 12'b000000000100,
		S_SCAN   = 12'b000000001000,
		S_SCANRD = 12'b000000010000,
		S_POP    = 12'b000000100000,
		S_POPRD  = 12'b000001000000,
		S_NB     = 12'b000010000000,
		S_NBRD   = 12'b000100000000,
		S_STORE  = 12'b001000000000,
		S_READ   = 12'b010000000000,
		S_READRD = 12'b100000000000
	} state_t;

	state_t state_q;
	logic [DW-1:0] width_q, height_q;
	logic [PW:0] load_q;
	logic [PW-1:0] p_q, tail_q;
	logic [PW:0] head_q, tail_cnt_q;
	logic [XW-1:0] x_q, sx_q;
	logic [YW-1:0] y_q, sy_q;
	logic [3:0] nb_q;
	box_t box_q;
	logic [LW-1:0] labels_q, count_q, rpos_q;
	logic ovf_q, dark_q;
	logic out_v_q;
	comp_t out_q;

	logic [XW:0] w_eff;
	logic [YW:0] h_eff;
	logic [PW:0] total;
	always_comb begin
		w_eff = (width_q == '0) ? (XW+1)'(1) :
			(width_q > DW'(MAX_WIDTH)) ? (XW+1)'(MAX_WIDTH) : (XW+1)'(width_q);
		h_eff = (height_q == '0) ? (YW+1)'(1) :
			(height_q > DW'(MAX_HEIGHT)) ? (YW+1)'(MAX_HEIGHT) : (YW+1)'(height_q);
	end
	logic [PW+1:0] total_full;
	assign total_full = w_eff * h_eff;
	assign total = total_full[PW:0];

	logic [XW:0] sx_inc;
	logic sx_wrap;
	assign sx_inc = (XW+1)'(sx_q) + 1'b1;
	assign sx_wrap = (sx_inc == w_eff);

	// memories
	logic dk_we, dk_wd, dk_rd, vi_we, vi_wd, vi_rd, qu_we, bx_we;
	logic [PW-1:0] dk_a, vi_a, qu_a, qu_wd, qu_rd;
	logic [CW-1:0] bx_a;
	box_t bx_rd;
	bcl_ram #(.WIDTH(1), .DEPTH(PIXELS)) u_dark (.clk, .we(dk_we), .addr(dk_a),
		.wdata(dk_wd), .rdata(dk_rd));
	bcl_ram #(.WIDTH(1), .DEPTH(PIXELS)) u_vis (.clk, .we(vi_we), .addr(vi_a),
		.wdata(vi_wd), .rdata(vi_rd));
	bcl_ram #(.WIDTH(PW), .DEPTH(PIXELS)) u_queue (.clk, .we(qu_we), .addr(qu_a),
		.wdata(qu_wd), .rdata(qu_rd));
	bcl_ram #(.WIDTH($bits(box_t)), .DEPTH(MAX_COMPONENTS)) u_box (.clk, .we(bx_we),
		.addr(bx_a), .wdata(box_q), .rdata(bx_rd));

	// neighbor address
	logic signed [2:0] dx, dy;
	logic [XW:0] nx;
	logic [YW:0] ny;
	logic nb_ok;
	logic [PW:0] n_addr;
	logic [PW+1:0] n_mul;
	always_comb begin
		dy = (nb_q inside {[4'd0:4'd2]}) ? -3'sd1 :
			(nb_q inside {[4'd3:4'd5]}) ? 3'sd0 : 3'sd1;
		dx = (nb_q inside {4'd0, 4'd3, 4'd6}) ? -3'sd1 :
			(nb_q inside {4'd1, 4'd4, 4'd7}) ? 3'sd0 : 3'sd1;
		nx = (XW+1)'(x_q) + (XW+1)'(signed'(dx));
		ny = (YW+1)'(y_q) + (YW+1)'(signed'(dy));
		nb_ok = !((dx < 0 && x_q == '0) || (dy < 0 && y_q == '0)) &&
			(nx < w_eff) && (ny < h_eff) && (nb_q != 4'd4);
		n_mul = ny * w_eff;
		n_addr = n_mul[PW:0] + (PW+1)'(nx);
	end

	logic [14:0] luma;
	assign luma = 15'(pix.data.red) * 15'd30 + 15'(pix.data.green) * 15'd59 +
		15'(pix.data.blue) * 15'd11;

	logic pix_fire;
	assign pix.ready = (state_q == S_IDLE) && !out_v_q;
	assign pix_fire = pix.valid && pix.ready;
	assign cfg.ready = (state_q == S_IDLE);
	assign comp.valid = out_v_q;
	assign comp.data = out_q;

	always_comb begin
		dk_we = 1'b0; dk_wd = dark_q; dk_a = load_q[PW-1:0];
		vi_we = 1'b0; vi_wd = 1'b0; vi_a = p_q;
		qu_we = 1'b0; qu_wd = {sy_q, sx_q}; qu_a = head_q[PW-1:0];
		bx_we = 1'b0; bx_a = rpos_q[CW-1:0];
		case (state_q)
			S_LOAD: dk_we = (load_q < (PW+1)'(PIXELS));
			S_CLEAR: vi_we = 1'b1;
			S_SCAN: begin dk_a = p_q; vi_a = p_q; end
			S_SCANRD: if (dk_rd && !vi_rd) begin
				vi_we = 1'b1; vi_wd = 1'b1; qu_we = 1'b1; qu_a = '0;
			end
			S_POP: qu_a = head_q[PW-1:0];
			S_NB: begin dk_a = n_addr[PW-1:0]; vi_a = n_addr[PW-1:0]; end
			S_NBRD: if (nb_ok && dk_rd && !vi_rd && tail_cnt_q < (PW+1)'(PIXELS)) begin
				vi_we = 1'b1; vi_wd = 1'b1; vi_a = n_addr[PW-1:0];
				qu_we = 1'b1; qu_a = tail_q; qu_wd = {ny[YW-1:0], nx[XW-1:0]};
			end
			S_STORE: begin
				bx_a = labels_q[CW-1:0];
				bx_we = (labels_q < LW'(MAX_COMPONENTS));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			width_q <= DW'(MAX_WIDTH); height_q <= DW'(MAX_HEIGHT);
			load_q <= '0; count_q <= '0; rpos_q <= '0; ovf_q <= 1'b0;
			out_v_q <= 1'b0; labels_q <= '0; out_q <= '0; dark_q <= 1'b0;
			p_q <= '0; head_q <= '0; tail_q <= '0; tail_cnt_q <= '0; nb_q <= '0;
			x_q <= '0; y_q <= '0; sx_q <= '0; sy_q <= '0; box_q <= '0;
		end else begin
			if (comp.valid && comp.ready) out_v_q <= 1'b0;
			if (cfg.valid && cfg.ready) begin
				if (cfg.data.index == REG_WIDTH) width_q <= cfg.data.data;
				else height_q <= cfg.data.data;
				load_q <= '0;
			end
			case (state_q)
				S_IDLE: if (pix_fire) begin
					if (pix.data.action == ACT_LOAD) begin
						dark_q <= (luma < 15'd12800);
						state_q <= S_LOAD;
					end else state_q <= S_READ;
				end
				S_LOAD: begin
					if (load_q + 1'b1 >= total) begin
						load_q <= '0; p_q <= '0; state_q <= S_CLEAR;
					end else begin
						load_q <= load_q + 1'b1; state_q <= S_IDLE;
					end
				end
				S_CLEAR: begin
					if ((PW+1)'(p_q) + 1'b1 >= total) begin
						p_q <= '0; labels_q <= '0; count_q <= '0; ovf_q <= 1'b0;
						sx_q <= '0; sy_q <= '0;
						rpos_q <= '0; state_q <= S_SCAN;
					end else p_q <= p_q + 1'b1;
				end
				S_SCAN: state_q <= S_SCANRD;
				S_SCANRD: begin
					if (dk_rd && !vi_rd) begin
						head_q <= '0; tail_q <= PW'(1); tail_cnt_q <= (PW+1)'(1);
						box_q <= '{sx_q, sy_q, sx_q, sy_q};
						state_q <= S_POP;
					end else if ((PW+1)'(p_q) + 1'b1 >= total) state_q <= S_IDLE;
					else begin
						p_q <= p_q + 1'b1; state_q <= S_SCAN;
						sx_q <= sx_wrap ? '0 : sx_inc[XW-1:0];
						if (sx_wrap) sy_q <= sy_q + 1'b1;
					end
				end
				S_POP: begin
					if (head_q >= tail_cnt_q) state_q <= S_STORE;
					else state_q <= S_POPRD;
				end
				S_POPRD: begin
					x_q <= qu_rd[XW-1:0];
					y_q <= qu_rd[PW-1:XW];
					head_q <= head_q + 1'b1;
					nb_q <= '0;
					state_q <= S_NB;
				end
				S_NB: begin
					if (x_q < box_q.left) box_q.left <= x_q;
					if (x_q > box_q.right) box_q.right <= x_q;
					if (y_q < box_q.top) box_q.top <= y_q;
					if (y_q > box_q.bottom) box_q.bottom <= y_q;
					state_q <= S_NBRD;
				end
				S_NBRD: begin
					if (nb_ok && dk_rd && !vi_rd && tail_cnt_q < (PW+1)'(PIXELS)) begin
						tail_q <= tail_q + 1'b1; tail_cnt_q <= tail_cnt_q + 1'b1;
					end
					if (nb_q == 4'd8) state_q <= S_POP;
					else begin nb_q <= nb_q + 1'b1; state_q <= S_NB; end
				end
				S_STORE: begin
					if (labels_q < LW'(MAX_COMPONENTS)) begin
						labels_q <= labels_q + 1'b1; count_q <= labels_q + 1'b1;
					end else ovf_q <= 1'b1;
					if ((PW+1)'(p_q) + 1'b1 >= total) state_q <= S_IDLE;
					else begin
						p_q <= p_q + 1'b1; state_q <= S_SCAN;
						sx_q <= sx_wrap ? '0 : sx_inc[XW-1:0];
						if (sx_wrap) sy_q <= sy_q + 1'b1;
					end
				end
				S_READ: state_q <= S_READRD;
				S_READRD: begin
					out_v_q <= 1'b1;
					out_q <= '0;
					out_q.table_overflow <= ovf_q;
					if (rpos_q < count_q) begin
						out_q.comp_valid <= 1'b1;
						out_q.comp_label <= rpos_q + 1'b1;
						out_q.box_left <= 8'(bx_rd.left);
						out_q.box_top <= 8'(bx_rd.top);
						out_q.box_right <= 8'(bx_rd.right);
						out_q.box_bottom <= 8'(bx_rd.bottom);
						out_q.last_component <= (rpos_q + 1'b1 == count_q);
						rpos_q <= rpos_q + 1'b1;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
